>>> design/bgi_pkg.sv
// Shared types and constants for the bilinear grid interpolator.
// Depends on nothing; every other design file but bgi_ram imports it.
`default_nettype none
package bgi_pkg;

	localparam int MAX_X_POINTS = 64;
	localparam int MAX_Y_POINTS = 64;
	localparam int X_AW         = $clog2(MAX_X_POINTS);
	localparam int Y_AW         = $clog2(MAX_Y_POINTS);
	localparam int W_DEPTH      = MAX_X_POINTS * MAX_Y_POINTS;
	localparam int W_AW         = $clog2(W_DEPTH);
	localparam int CNT_W        = 7;
	localparam int FRAC_W       = 16;
	localparam int DCNT_W       = $clog2(FRAC_W);

	localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

	localparam logic REG_X_COUNT = 1'b0;
	localparam logic REG_Y_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_X = 2'd0,
		OP_LOAD_Y = 2'd1,
		OP_LOAD_W = 2'd2,
		OP_QUERY  = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [5:0]         x_index;
		logic [5:0]         y_index;
		logic signed [31:0] load_value;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               inside_res;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_B0, ST_RD_B1, ST_BCHK, ST_SRCH_A, ST_SRCH_D,
		ST_RD_C0, ST_RD_C1, ST_DIFF, ST_NORM, ST_DIV,
		ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_M0, ST_M1, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		CMD_IDLE, CMD_RD_B0, CMD_RD_B1, CMD_BCHK, CMD_SRCH_A, CMD_SRCH_D,
		CMD_RD_C0, CMD_RD_C1, CMD_DIFF, CMD_NORM, CMD_DIV,
		CMD_W0, CMD_W1, CMD_W2, CMD_W3, CMD_W4, CMD_M0, CMD_M1, CMD_OUT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    accept;
	} dp_cmd_t;

	typedef struct packed {
		logic outside;
		logic zero_span;
		logic srch_done;
	} dp_status_t;

endpackage
`default_nettype wire

>>> design/bgi_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bgi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> design/bgi_ctrl.sv
// Query sequencer for the bilinear grid interpolator.
// Depends on bgi_pkg; drives bgi_dp through dp_cmd_t, reads dp_status_t.
`default_nettype none
module bgi_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire bgi_pkg::opcode_t    opcode,
	input  wire bgi_pkg::dp_status_t status,
	output bgi_pkg::dp_cmd_t         cmd,
	output logic                     busy,
	output logic                     done
);
	import bgi_pkg::*;

	state_t             state_q, state_nxt;
	logic [DCNT_W-1:0]  dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 1'b1;
			end else begin
				dcnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (start && opcode == OP_QUERY) state_nxt = ST_RD_B0;
			ST_RD_B0:  state_nxt = ST_RD_B1;
			ST_RD_B1:  state_nxt = ST_BCHK;
			ST_BCHK:   state_nxt = status.outside ? ST_OUT : ST_SRCH_A;
			ST_SRCH_A: state_nxt = status.srch_done ? ST_RD_C0 : ST_SRCH_D;
			ST_SRCH_D: state_nxt = ST_SRCH_A;
			ST_RD_C0:  state_nxt = ST_RD_C1;
			ST_RD_C1:  state_nxt = ST_DIFF;
			ST_DIFF:   state_nxt = ST_NORM;
			ST_NORM:   state_nxt = status.zero_span ? ST_OUT : ST_DIV;
			ST_DIV:    if (dcnt_q == DCNT_W'(FRAC_W - 1)) state_nxt = ST_W0;
			ST_W0:     state_nxt = ST_W1;
			ST_W1:     state_nxt = ST_W2;
			ST_W2:     state_nxt = ST_W3;
			ST_W3:     state_nxt = ST_W4;
			ST_W4:     state_nxt = ST_M0;
			ST_M0:     state_nxt = ST_M1;
			ST_M1:     state_nxt = ST_OUT;
			ST_OUT:    state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && start;
		busy       = (state_q != ST_IDLE);
		done       = (state_q == ST_OUT);
		unique case (state_q)
			ST_IDLE:   cmd.op = CMD_IDLE;
			ST_RD_B0:  cmd.op = CMD_RD_B0;
			ST_RD_B1:  cmd.op = CMD_RD_B1;
			ST_BCHK:   cmd.op = CMD_BCHK;
			ST_SRCH_A: cmd.op = CMD_SRCH_A;
			ST_SRCH_D: cmd.op = CMD_SRCH_D;
			ST_RD_C0:  cmd.op = CMD_RD_C0;
			ST_RD_C1:  cmd.op = CMD_RD_C1;
			ST_DIFF:   cmd.op = CMD_DIFF;
			ST_NORM:   cmd.op = CMD_NORM;
			ST_DIV:    cmd.op = CMD_DIV;
			ST_W0:     cmd.op = CMD_W0;
			ST_W1:     cmd.op = CMD_W1;
			ST_W2:     cmd.op = CMD_W2;
			ST_W3:     cmd.op = CMD_W3;
			ST_W4:     cmd.op = CMD_W4;
			ST_M0:     cmd.op = CMD_M0;
			ST_M1:     cmd.op = CMD_M1;
			ST_OUT:    cmd.op = CMD_OUT;
			default:   cmd.op = CMD_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> design/bgi_dp.sv
// Datapath: axis and weight memories, searches, fraction dividers, blend MAC.
// Depends on bgi_pkg and bgi_ram; sequenced by bgi_ctrl.
`default_nettype none
module bgi_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bgi_pkg::in_word_t in_word,
	input  wire bgi_pkg::dp_cmd_t  cmd,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [6:0]        cfg_data,
	output bgi_pkg::dp_status_t    status,
	output bgi_pkg::out_word_t     out_word
);
	import bgi_pkg::*;

	// config
	logic [CNT_W-1:0] xcnt_q, ycnt_q, cfg_clamped;
	always_comb begin
		if (cfg_data < CNT_W'(2)) cfg_clamped = CNT_W'(2);
		else if (cfg_data > CNT_W'(MAX_X_POINTS) && cfg_index == REG_X_COUNT)
			cfg_clamped = CNT_W'(MAX_X_POINTS);
		else if (cfg_data > CNT_W'(MAX_Y_POINTS) && cfg_index == REG_Y_COUNT)
			cfg_clamped = CNT_W'(MAX_Y_POINTS);
		else cfg_clamped = cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xcnt_q <= CNT_W'(2);
			ycnt_q <= CNT_W'(2);
		end else if (cfg_we) begin
			if (cfg_index == REG_X_COUNT) xcnt_q <= cfg_clamped;
			else ycnt_q <= cfg_clamped;
		end
	end

	function automatic logic [CNT_W-1:0] cell_of(input logic [CNT_W-1:0] ub,
	                                             input logic [CNT_W-1:0] n);
		if (ub >= n) return n - CNT_W'(2);
		else if (ub == '0) return '0;
		else return ub - 1'b1;
	endfunction

	// query operands
	logic signed [31:0] qx_q, qy_q;
	logic               load_x, load_y, load_w;
	always_ff @(posedge clk) begin
		if (cmd.accept && in_word.opcode == OP_QUERY) begin
			qx_q <= in_word.query_x;
			qy_q <= in_word.query_y;
		end
	end
	assign load_x = cmd.accept && in_word.opcode == OP_LOAD_X
	                && 32'(in_word.x_index) < MAX_X_POINTS;
	assign load_y = cmd.accept && in_word.opcode == OP_LOAD_Y
	                && 32'(in_word.y_index) < MAX_Y_POINTS;
	assign load_w = cmd.accept && in_word.opcode == OP_LOAD_W
	                && 32'(in_word.x_index) < MAX_X_POINTS
	                && 32'(in_word.y_index) < MAX_Y_POINTS;

	// search state
	logic [CNT_W-1:0] xf_q, xc_q, yf_q, yc_q;
	logic [CNT_W-1:0] x_step, x_it, y_step, y_it, ix, iy;
	assign x_step = xc_q >> 1;
	assign x_it   = xf_q + x_step;
	assign y_step = yc_q >> 1;
	assign y_it   = yf_q + y_step;
	assign ix     = cell_of(xf_q, xcnt_q);
	assign iy     = cell_of(yf_q, ycnt_q);

	// memories
	logic [X_AW-1:0] x_raddr;
	logic [Y_AW-1:0] y_raddr;
	logic [W_AW-1:0] w_raddr;
	logic [CNT_W-1:0] wx, wy;
	logic signed [31:0] x_rd, y_rd, w_rd;

	always_comb begin
		unique case (cmd.op)
			CMD_RD_B1:              x_raddr = X_AW'(xcnt_q - 1'b1);
			CMD_SRCH_A, CMD_SRCH_D: x_raddr = X_AW'(x_it);
			CMD_RD_C0:              x_raddr = X_AW'(ix);
			CMD_RD_C1:              x_raddr = X_AW'(ix + 1'b1);
			default:                x_raddr = '0;
		endcase
		unique case (cmd.op)
			CMD_RD_B1:              y_raddr = Y_AW'(ycnt_q - 1'b1);
			CMD_SRCH_A, CMD_SRCH_D: y_raddr = Y_AW'(y_it);
			CMD_RD_C0:              y_raddr = Y_AW'(iy);
			CMD_RD_C1:              y_raddr = Y_AW'(iy + 1'b1);
			default:                y_raddr = '0;
		endcase
		wx = ((cmd.op == CMD_W1) || (cmd.op == CMD_W3)) ? ix + 1'b1 : ix;
		wy = ((cmd.op == CMD_W2) || (cmd.op == CMD_W3)) ? iy + 1'b1 : iy;
		w_raddr = W_AW'(32'(wx) * MAX_Y_POINTS + 32'(wy));
	end

	bgi_ram #(.WIDTH(32), .DEPTH(MAX_X_POINTS)) u_xram (
		.clk(clk), .we(load_x), .waddr(X_AW'(in_word.x_index)),
		.wdata(in_word.load_value), .raddr(x_raddr), .rdata(x_rd)
	);
	bgi_ram #(.WIDTH(32), .DEPTH(MAX_Y_POINTS)) u_yram (
		.clk(clk), .we(load_y), .waddr(Y_AW'(in_word.y_index)),
		.wdata(in_word.load_value), .raddr(y_raddr), .rdata(y_rd)
	);
	bgi_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_wram (
		.clk(clk), .we(load_w),
		.waddr(W_AW'(32'(in_word.x_index) * MAX_Y_POINTS + 32'(in_word.y_index))),
		.wdata(in_word.load_value), .raddr(w_raddr), .rdata(w_rd)
	);

	// lower corner / first axis point
	logic signed [31:0] lo_x_q, lo_y_q;
	logic signed [32:0] ax_q, dx_q, ay_q, dy_q;
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_RD_B1 || cmd.op == CMD_RD_C1) begin
			lo_x_q <= x_rd;
			lo_y_q <= y_rd;
		end
		if (cmd.op == CMD_DIFF) begin
			ax_q <= 33'(qx_q) - 33'(lo_x_q);
			dx_q <= 33'(x_rd) - 33'(lo_x_q);
			ay_q <= 33'(qy_q) - 33'(lo_y_q);
			dy_q <= 33'(y_rd) - 33'(lo_y_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_BCHK) begin
			xf_q <= '0;
			xc_q <= xcnt_q;
			yf_q <= '0;
			yc_q <= ycnt_q;
		end else if (cmd.op == CMD_SRCH_D) begin
			if (xc_q != '0) begin
				if (!(qx_q < x_rd)) begin
					xf_q <= x_it + 1'b1;
					xc_q <= xc_q - x_step - 1'b1;
				end else begin
					xc_q <= x_step;
				end
			end
			if (yc_q != '0) begin
				if (!(qy_q < y_rd)) begin
					yf_q <= y_it + 1'b1;
					yc_q <= yc_q - y_step - 1'b1;
				end else begin
					yc_q <= y_step;
				end
			end
		end
	end

	// fraction dividers, restoring, one quotient bit per cycle each
	logic signed [33:0] anx, dnx, any, dny;
	logic [33:0]        remx_q, remy_q, dvx_q, dvy_q;
	logic [FRAC_W:0]    tx_q, ty_q;
	logic               actx_q, acty_q;
	logic [34:0]        r2x, r2y;
	logic               bx, by;

	always_comb begin
		if (dx_q < 0) begin
			anx = -34'(ax_q);
			dnx = -34'(dx_q);
		end else begin
			anx = 34'(ax_q);
			dnx = 34'(dx_q);
		end
		if (dy_q < 0) begin
			any = -34'(ay_q);
			dny = -34'(dy_q);
		end else begin
			any = 34'(ay_q);
			dny = 34'(dy_q);
		end
		r2x = {remx_q, 1'b0};
		r2y = {remy_q, 1'b0};
		bx  = r2x >= {1'b0, dvx_q};
		by  = r2y >= {1'b0, dvy_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_NORM) begin
			remx_q <= anx;
			dvx_q  <= dnx;
			remy_q <= any;
			dvy_q  <= dny;
			actx_q <= 1'b0;
			acty_q <= 1'b0;
			if (anx <= 0) tx_q <= '0;
			else if (anx >= dnx) tx_q <= FRAC_ONE;
			else begin
				tx_q   <= '0;
				actx_q <= 1'b1;
			end
			if (any <= 0) ty_q <= '0;
			else if (any >= dny) ty_q <= FRAC_ONE;
			else begin
				ty_q   <= '0;
				acty_q <= 1'b1;
			end
		end else if (cmd.op == CMD_DIV) begin
			if (actx_q) begin
				remx_q <= bx ? 34'(r2x - {1'b0, dvx_q}) : r2x[33:0];
				tx_q   <= {tx_q[FRAC_W-1:0], bx};
			end
			if (acty_q) begin
				remy_q <= by ? 34'(r2y - {1'b0, dvy_q}) : r2y[33:0];
				ty_q   <= {ty_q[FRAC_W-1:0], by};
			end
		end
	end

	// blend: a = w00(1-tx)+w10 tx, b = w01(1-tx)+w11 tx, acc = a(1-ty)+b ty
	logic signed [49:0] a_q, b_q, m_a;
	logic signed [17:0] m_b;
	logic signed [67:0] prod;
	logic signed [63:0] acc_q, rnd;
	logic [FRAC_W:0]    omx, omy;
	logic               inside_q;

	assign omx = FRAC_ONE - tx_q;
	assign omy = FRAC_ONE - ty_q;

	always_comb begin
		unique case (cmd.op)
			CMD_M0:  m_a = a_q;
			CMD_M1:  m_a = b_q;
			default: m_a = 50'(w_rd);
		endcase
		unique case (cmd.op)
			CMD_W2, CMD_W4: m_b = $signed({1'b0, tx_q});
			CMD_M0:         m_b = $signed({1'b0, omy});
			CMD_M1:         m_b = $signed({1'b0, ty_q});
			default:        m_b = $signed({1'b0, omx});
		endcase
		prod = 68'(m_a) * 68'(m_b);
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_W1:  a_q   <= prod[49:0];
			CMD_W2:  a_q   <= a_q + prod[49:0];
			CMD_W3:  b_q   <= prod[49:0];
			CMD_W4:  b_q   <= b_q + prod[49:0];
			CMD_M0:  acc_q <= prod[63:0];
			CMD_M1:  acc_q <= acc_q + prod[63:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (cmd.accept) begin
			inside_q <= 1'b0;
		end else if (cmd.op == CMD_M1) begin
			inside_q <= 1'b1;
		end
	end

	// convex blend always fits; round half up from Q32.32
	assign rnd                   = acc_q + 64'sh8000_0000;
	assign out_word.interp_value = inside_q ? rnd[63:32] : '0;
	assign out_word.inside_res   = inside_q;

	assign status.outside   = (qx_q < lo_x_q) || (qx_q > x_rd)
	                        || (qy_q < lo_y_q) || (qy_q > y_rd);
	assign status.zero_span = (dx_q == '0) || (dy_q == '0);
	assign status.srch_done = (xc_q == '0) && (yc_q == '0);
endmodule
`default_nettype wire

>>> design/bilinear_grid_interp_zero_outside_unit.sv
// Bilinear interpolator over a non-uniform grid, zero outside the axes or in a
// zero-width cell. Loads are written in the accept cycle and never raise busy. A
// query that falls outside the axes goes from the bounds check straight to done;
// one inside runs a halving axis search (both axes in parallel), a restoring
// division and a blend on one multiplier. Results cannot be stalled. arst_n clears the
// sequencer and sets both counts to 2; memory contents are kept.
`default_nettype none
module bilinear_grid_interp_zero_outside_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire bgi_pkg::in_word_t in_word,
	output logic                   done,
	output bgi_pkg::out_word_t     out_word,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [6:0]        cfg_data
);
	import bgi_pkg::*;

	// control <-> datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: one query at a time, loads handled in the accept cycle
	bgi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(in_word.opcode),
		.status(status), .cmd(cmd), .busy(busy), .done(done)
	);

	// storage, search, divide, blend
	bgi_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.status(status), .out_word(out_word)
	);
endmodule
`default_nettype wire

>>> design/bgi_checker.sv
// Port-level checks for the interpolator, bound to the top level.
// Depends on bgi_pkg.
`default_nettype none
module bgi_assert (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire bgi_pkg::in_word_t  in_word,
	input wire logic               done,
	input wire bgi_pkg::out_word_t out_word
);
	import bgi_pkg::*;

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_word.opcode == OP_QUERY |=> busy)
		else $error("query accepted without going busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result word repeated");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result word outside a query");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_word.inside_res |-> out_word.interp_value == 0)
		else $error("nonzero value for outside query");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("query ended without result");
endmodule

bind bilinear_grid_interp_zero_outside_unit bgi_assert u_bgi_assert (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.in_word(in_word), .done(done), .out_word(out_word)
);
`default_nettype wire

>>> sim/bgi_checker.sv
// Checker for the bilinear grid interpolator: watches accepted words and results,
// keeps its own copy of the axes, weights and counts, predicts and compares.
// Depends on bgi_pkg.
module bgi_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  bgi_pkg::in_word_t       in_word,
	input  wire logic               done,
	input  bgi_pkg::out_word_t      out_word,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [6:0]         cfg_data,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bgi_pkg::*;

	logic signed [31:0] xs [MAX_X_POINTS];
	logic signed [31:0] ys [MAX_Y_POINTS];
	logic signed [31:0] ws [W_DEPTH];
	int unsigned nx = 2, ny = 2;
	out_word_t interp_q [$];

	assign pending = interp_q.size();

	function automatic int unsigned clamp_cnt(logic [6:0] v, int unsigned mx);
		int unsigned c;
		c = v;
		if (c < 2) c = 2;
		if (c > mx) c = mx;
		return c;
	endfunction

	function automatic int unsigned first_above(bit is_x, int unsigned n,
			logic signed [31:0] q);
		int unsigned first, cnt, stp, it;
		logic signed [31:0] a;
		first = 0;
		cnt = n;
		while (cnt > 0) begin
			stp = cnt / 2;
			it = first + stp;
			a = is_x ? xs[it] : ys[it];
			if (!(q < a)) begin
				first = it + 1;
				cnt -= stp + 1;
			end else
				cnt = stp;
		end
		return first;
	endfunction

	function automatic int unsigned cell_idx(int unsigned ub, int unsigned n);
		if (ub >= n) return n - 2;
		return (ub == 0) ? 0 : ub - 1;
	endfunction

	function automatic longint unsigned frac16(longint a, longint d);
		if (d < 0) begin
			a = -a;
			d = -d;
		end
		if (a <= 0) return 0;
		if (a >= d) return 65536;
		return (longint'(a) << 16) / d;
	endfunction

	function automatic out_word_t blend(logic signed [31:0] qx, logic signed [31:0] qy);
		out_word_t r;
		int unsigned ix, iy;
		longint dx, dy, tx, ty;
		logic signed [127:0] acc;
		r = '0;
		if (qx < xs[0] || qx > xs[nx-1] || qy < ys[0] || qy > ys[ny-1]) return r;
		ix = cell_idx(first_above(1, nx, qx), nx);
		iy = cell_idx(first_above(0, ny, qy), ny);
		dx = longint'(xs[ix+1]) - longint'(xs[ix]);
		dy = longint'(ys[iy+1]) - longint'(ys[iy]);
		if (dx == 0 || dy == 0) return r;
		tx = frac16(longint'(qx) - longint'(xs[ix]), dx);
		ty = frac16(longint'(qy) - longint'(ys[iy]), dy);
		acc = 128'sd0;
		acc += 128'(ws[ix*MAX_Y_POINTS+iy]) * 128'((65536-tx)*(65536-ty));
		acc += 128'(ws[(ix+1)*MAX_Y_POINTS+iy]) * 128'(tx*(65536-ty));
		acc += 128'(ws[ix*MAX_Y_POINTS+iy+1]) * 128'((65536-tx)*ty);
		acc += 128'(ws[(ix+1)*MAX_Y_POINTS+iy+1]) * 128'(tx*ty);
		// round half up, arithmetic shift floors
		acc = (acc + 128'sh80000000) >>> 32;
		if (acc > 128'sd2147483647) acc = 128'sd2147483647;
		if (acc < -128'sd2147483648) acc = -128'sd2147483648;
		r.interp_value = acc[31:0];
		r.inside_res = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			nx = 2;
			ny = 2;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_X_COUNT) nx = clamp_cnt(cfg_data, MAX_X_POINTS);
				else ny = clamp_cnt(cfg_data, MAX_Y_POINTS);
			end
			if (done) begin
				if (interp_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					e = interp_q.pop_front();
					if (out_word.interp_value !== e.interp_value) begin
						$error("interp_value expected %0d got %0d",
							e.interp_value, out_word.interp_value);
						fail_count++;
					end
					if (out_word.inside_res !== e.inside_res) begin
						$error("inside_res expected %0d got %0d",
							e.inside_res, out_word.inside_res);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				case (in_word.opcode)
					OP_LOAD_X: xs[in_word.x_index] = in_word.load_value;
					OP_LOAD_Y: ys[in_word.y_index] = in_word.load_value;
					OP_LOAD_W: ws[in_word.x_index*MAX_Y_POINTS + in_word.y_index]
						= in_word.load_value;
					default: interp_q = {interp_q,
						blend(in_word.query_x, in_word.query_y)};
				endcase
			end
		end
	end
endmodule

>>> sim/testbench.sv
// Top of the interpolator testbench: clock, reset, directed and random command
// words, count writes between phases, and the verdict. Depends on bgi_pkg,
// bgi_checker and the unit under test.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bgi_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	in_word_t in_word = '0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;
	int fail_count, pending;
	int cycles = 0;
	bit calm = 0;   // no idle gaps while set

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bilinear_grid_interp_zero_outside_unit dut (.*);
	bgi_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Drive one word and hold start until the unit takes it; start stays up
	// for the next word unless an idle gap drops it.
	task automatic issue(in_word_t w);
		if (!calm)
			while ($urandom_range(99) < 9) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_count(logic idx, logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_word_t mk(opcode_t op, int xi, int yi, logic [31:0] lv,
			logic [31:0] qx, logic [31:0] qy);
		in_word_t w;
		w.opcode = op;
		w.x_index = 6'(xi);
		w.y_index = 6'(yi);
		w.load_value = lv;
		w.query_x = qx;
		w.query_y = qy;
		return w;
	endfunction

	function automatic logic [31:0] rnd32;
		return $urandom;
	endfunction

	// Ascending axes with random spacing (occasional zero step) over the points
	// in use, so every later axis read hits written entries.
	task automatic load_grid(bit wide);
		int a, b, s;
		a = wide ? -32'sd2000000000 : -($urandom_range(300000));
		b = a;
		for (int i = 0; i < chk.nx; i++) begin
			issue(mk(OP_LOAD_X, i, $urandom_range(63), a, rnd32(), rnd32()));
			s = ($urandom_range(19) == 0) ? 0 : $urandom_range(wide ? 60000000 : 20000);
			a += s;
		end
		for (int i = 0; i < chk.ny; i++) begin
			issue(mk(OP_LOAD_Y, $urandom_range(63), i, b, rnd32(), rnd32()));
			s = ($urandom_range(19) == 0) ? 0 : $urandom_range(wide ? 60000000 : 20000);
			b += s;
		end
	endtask

	// Weights for every corner that the counts in use can reach.
	task automatic load_weights;
		logic [31:0] v;
		for (int i = 0; i < chk.nx; i++)
			for (int j = 0; j < chk.ny; j++) begin
				case ($urandom_range(9))
					0: v = 32'h7fffffff;
					1: v = 32'h80000000;
					default: v = rnd32();
				endcase
				issue(mk(OP_LOAD_W, i, j, v, rnd32(), rnd32()));
			end
	endtask

	// Query mostly inside the span, sometimes outside or on a grid point.
	task automatic rand_query(int n);
		logic [31:0] qx, qy;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: begin qx = rnd32(); qy = rnd32(); end
				1: begin qx = 32'h80000000; qy = 32'h7fffffff; end
				default: begin
					qx = $signed(chk.xs[0]) +
						$urandom_range(chk.xs[chk.nx-1] - chk.xs[0]);
					qy = $signed(chk.ys[0]) +
						$urandom_range(chk.ys[chk.ny-1] - chk.ys[0]);
				end
			endcase
			if ($urandom_range(7) == 0) qx = chk.xs[$urandom_range(chk.nx-1)];
			if ($urandom_range(7) == 0) qy = chk.ys[$urandom_range(chk.ny-1)];
			issue(mk(OP_QUERY, $urandom, $urandom, rnd32(), qx, qy));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the grid, then corners, ends and outside points at reset counts.
		calm = 1;
		load_grid(0);
		load_weights;
		calm = 0;
		issue(mk(OP_QUERY, 0, 0, 0, chk.xs[0], chk.ys[0]));
		issue(mk(OP_QUERY, 0, 0, 0, chk.xs[1], chk.ys[1]));
		issue(mk(OP_QUERY, 0, 0, 0, chk.xs[0] - 1, chk.ys[0]));
		issue(mk(OP_QUERY, 0, 0, 0, chk.xs[0], chk.ys[1] + 1));
		issue(mk(OP_QUERY, 63, 63, 32'hffffffff, 32'h80000000, 32'h7fffffff));
		// Non-ascending y: first cell collapses or runs backward.
		issue(mk(OP_LOAD_Y, 0, 1, chk.ys[0] - 1000, 0, 0));
		issue(mk(OP_QUERY, 0, 0, 0, chk.xs[0], chk.ys[0]));
		issue(mk(OP_LOAD_Y, 0, 1, chk.ys[0], 0, 0));
		issue(mk(OP_QUERY, 0, 0, 0, chk.xs[0], chk.ys[0]));
		rand_query(10);
		settle();

		// Phases across count settings, extremes included, each with a fresh grid.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_count(REG_X_COUNT, 7'd64); write_count(REG_Y_COUNT, 7'd1); end
				1: begin write_count(REG_X_COUNT, 7'd0);  write_count(REG_Y_COUNT, 7'd127); end
				2: begin write_count(REG_X_COUNT, 7'd3);  write_count(REG_Y_COUNT, 7'd5); end
				default: begin
					write_count(REG_X_COUNT, 7'($urandom_range(8)));
					write_count(REG_Y_COUNT, 7'($urandom_range(8)));
				end
			endcase
			calm = (ph == 2);
			load_grid(ph % 2);
			load_weights;
			rand_query(40);
			settle();
		end

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
